// ===== sv/sip_pkg.sv =====
// Shared types, mode codes and rounding averages for the 4x4 intra subblock predictor.
// Depends on nothing; used by subblock_intra_predictor_top.
package sip_pkg;

  typedef logic [7:0] pix_t;
  typedef logic [31:0] row_t;
  typedef logic [3:0] mode_t;

  localparam mode_t MODE_DC = 4'd0;
  localparam mode_t MODE_TM = 4'd1;
  localparam mode_t MODE_VE = 4'd2;
  localparam mode_t MODE_HE = 4'd3;
  localparam mode_t MODE_LD = 4'd4;
  localparam mode_t MODE_RD = 4'd5;
  localparam mode_t MODE_VR = 4'd6;
  localparam mode_t MODE_VL = 4'd7;
  localparam mode_t MODE_HD = 4'd8;
  localparam mode_t MODE_HU = 4'd9;

  localparam int EDGE_LEN = 14; // left 3..0, corner, above 0..7, above 7 again
  localparam int AVG3_LEN = 12;
  localparam int AVG2_LEN = 9;

  // (a + 2b + c + 2) >> 2
  function automatic pix_t avg3(input pix_t a, input pix_t b, input pix_t c);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
    return s[9:2];
  endfunction

  // (a + b + 1) >> 1
  function automatic pix_t avg2(input pix_t a, input pix_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

endpackage

// ===== sv/subblock_intra_predictor_top.sv =====
// Top level of the 4x4 intra subblock predictor: request pipeline and row output stage.
// Depends on sip_pkg for types, mode codes and the rounding averages.
//
// Takes one prediction request (mode, eight above pixels, four left pixels and the
// corner pixel) and returns the 4x4 prediction as four row results, top row first,
// with the row number on m_tuser and m_tlast on the bottom row. The block holds no
// state between requests. A request passes an input register, an averaging stage
// (all 3-tap averages along the edge, 2-tap averages up to above 4, DC mean,
// TrueMotion differences), a block assembly stage and the output stage. The output
// stage sends one row per cycle while m_tready is high and takes the next block only
// once the bottom row is accepted; the three earlier stages take a new request each
// cycle while they have room, which hides short output stalls.
// Undefined mode codes give all-zero rows.
module subblock_intra_predictor_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // mode[3:0], above_pixels[67:4], left_pixels[99:68],
                                 // corner_pixel[107:100], zero pad[111:108]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,  // row_pixels[31:0]
  output logic [1:0]   m_tuser,  // row_index[1:0]
  output logic         m_tlast   // last_row
);

  // ---------------------------------------------------------------- handshake chain
  logic s1_valid, s2_valid, s3_valid, out_valid;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic [1:0] out_row;

  assign out_ready = !out_valid || (m_tready && (out_row == 2'd3));
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s_tready  = s1_ready;

  // ---------------------------------------------------------------- stage 1: capture
  // Edge runs from left 3 up through the corner to above 7; above 7 is repeated
  // at the end so the bottom-right diagonal tap needs no special case.
  sip_pkg::mode_t s1_mode;
  sip_pkg::pix_t  s1_edge [sip_pkg::EDGE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s_tvalid) begin
      s1_mode <= s_tdata[3:0];
      for (int i = 0; i < 4; i++) begin
        s1_edge[3 - i] <= s_tdata[68 + 8 * i +: 8];
      end
      s1_edge[4] <= s_tdata[107:100];
      for (int i = 0; i < 8; i++) begin
        s1_edge[5 + i] <= s_tdata[4 + 8 * i +: 8];
      end
      s1_edge[13] <= s_tdata[67:60];
    end
  end

  // ---------------------------------------------------------------- stage 2: averages
  sip_pkg::mode_t   s2_mode;
  sip_pkg::pix_t    s2_g3 [sip_pkg::AVG3_LEN];
  sip_pkg::pix_t    s2_g2 [sip_pkg::AVG2_LEN];
  sip_pkg::pix_t    s2_hu3;          // avg3(left 2, left 3, left 3)
  sip_pkg::pix_t    s2_dc;
  logic signed [8:0] s2_tmd [4];     // above c minus corner
  sip_pkg::pix_t    s2_left [4];

  logic [10:0] dc_sum;

  always_comb begin
    dc_sum = 11'd4;
    for (int i = 0; i < 4; i++) begin
      dc_sum = dc_sum + {3'b000, s1_edge[i]} + {3'b000, s1_edge[5 + i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_mode <= s1_mode;
      for (int k = 0; k < sip_pkg::AVG3_LEN; k++) begin
        s2_g3[k] <= sip_pkg::avg3(s1_edge[k], s1_edge[k + 1], s1_edge[k + 2]);
      end
      for (int k = 0; k < sip_pkg::AVG2_LEN; k++) begin
        s2_g2[k] <= sip_pkg::avg2(s1_edge[k], s1_edge[k + 1]);
      end
      s2_hu3 <= sip_pkg::avg3(s1_edge[1], s1_edge[0], s1_edge[0]);
      s2_dc  <= dc_sum[10:3];
      for (int c = 0; c < 4; c++) begin
        s2_tmd[c]  <= $signed({1'b0, s1_edge[5 + c]}) - $signed({1'b0, s1_edge[4]});
        s2_left[c] <= s1_edge[3 - c];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: assemble
  sip_pkg::pix_t  blk [4][4];
  sip_pkg::row_t  s3_rows [4];
  logic signed [9:0] tm_sum;

  always_comb begin
    tm_sum = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        blk[r][c] = '0;
      end
    end
    unique case (s2_mode)
      sip_pkg::MODE_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            blk[r][c] = s2_dc;
          end
        end
      end
      sip_pkg::MODE_TM: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            tm_sum = $signed({2'b00, s2_left[r]}) + 10'(s2_tmd[c]);
            // clamp to 0..255
            if (tm_sum[9]) begin
              blk[r][c] = 8'd0;
            end else if (tm_sum[8]) begin
              blk[r][c] = 8'd255;
            end else begin
              blk[r][c] = tm_sum[7:0];
            end
          end
        end
      end
      sip_pkg::MODE_VE: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            blk[r][c] = s2_g3[4 + c];
          end
        end
      end
      sip_pkg::MODE_HE: begin
        for (int c = 0; c < 4; c++) begin
          blk[0][c] = s2_g3[2];
          blk[1][c] = s2_g3[1];
          blk[2][c] = s2_g3[0];
          blk[3][c] = s2_hu3;
        end
      end
      sip_pkg::MODE_LD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            blk[r][c] = s2_g3[5 + r + c];
          end
        end
      end
      sip_pkg::MODE_RD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            blk[r][c] = s2_g3[3 - r + c];
          end
        end
      end
      sip_pkg::MODE_VR: begin
        blk[3][0] = s2_g3[1];
        blk[2][0] = s2_g3[2];
        blk[3][1] = s2_g3[3]; blk[1][0] = s2_g3[3];
        blk[2][1] = s2_g2[4]; blk[0][0] = s2_g2[4];
        blk[3][2] = s2_g3[4]; blk[1][1] = s2_g3[4];
        blk[2][2] = s2_g2[5]; blk[0][1] = s2_g2[5];
        blk[3][3] = s2_g3[5]; blk[1][2] = s2_g3[5];
        blk[2][3] = s2_g2[6]; blk[0][2] = s2_g2[6];
        blk[1][3] = s2_g3[6];
        blk[0][3] = s2_g2[7];
      end
      sip_pkg::MODE_VL: begin
        blk[0][0] = s2_g2[5];
        blk[1][0] = s2_g3[5];
        blk[2][0] = s2_g2[6]; blk[0][1] = s2_g2[6];
        blk[1][1] = s2_g3[6]; blk[3][0] = s2_g3[6];
        blk[2][1] = s2_g2[7]; blk[0][2] = s2_g2[7];
        blk[3][1] = s2_g3[7]; blk[1][2] = s2_g3[7];
        blk[0][3] = s2_g2[8]; blk[2][2] = s2_g2[8];
        blk[1][3] = s2_g3[8]; blk[3][2] = s2_g3[8];
        blk[2][3] = s2_g3[9];
        blk[3][3] = s2_g3[10];
      end
      sip_pkg::MODE_HD: begin
        blk[3][0] = s2_g2[0];
        blk[3][1] = s2_g3[0];
        blk[2][0] = s2_g2[1]; blk[3][2] = s2_g2[1];
        blk[2][1] = s2_g3[1]; blk[3][3] = s2_g3[1];
        blk[2][2] = s2_g2[2]; blk[1][0] = s2_g2[2];
        blk[2][3] = s2_g3[2]; blk[1][1] = s2_g3[2];
        blk[1][2] = s2_g2[3]; blk[0][0] = s2_g2[3];
        blk[1][3] = s2_g3[3]; blk[0][1] = s2_g3[3];
        blk[0][2] = s2_g3[4];
        blk[0][3] = s2_g3[5];
      end
      sip_pkg::MODE_HU: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            blk[r][c] = s2_left[3];
          end
        end
        blk[0][0] = s2_g2[2];
        blk[0][1] = s2_g3[1];
        blk[0][2] = s2_g2[1]; blk[1][0] = s2_g2[1];
        blk[0][3] = s2_g3[0]; blk[1][1] = s2_g3[0];
        blk[1][2] = s2_g2[0]; blk[2][0] = s2_g2[0];
        blk[1][3] = s2_hu3;   blk[2][1] = s2_hu3;
      end
      default: begin
        // undefined mode: rows stay zero
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      for (int r = 0; r < 4; r++) begin
        s3_rows[r] <= {blk[r][3], blk[r][2], blk[r][1], blk[r][0]};
      end
    end
  end

  // ---------------------------------------------------------------- output stage
  // Hold the finished block and step through its rows, one per accepted transfer.
  sip_pkg::row_t out_rows [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_row   <= 2'd0;
    end else if (out_ready) begin
      out_valid <= s3_valid;
      out_row   <= 2'd0;
    end else if (m_tready) begin
      out_row <= out_row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s3_valid) begin
      out_rows <= s3_rows;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_rows[out_row];
  assign m_tuser  = out_row;
  assign m_tlast  = (out_row == 2'd3);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for subblock_intra_predictor_top: streams 4x4 intra prediction requests
// and checks every row result against a behavioural predictor held here.
// Depends on sip_pkg (types, mode codes) and the top level RTL.
module tb_top;

  // Mode codes the block does not define; they must still give four zero rows
  localparam sip_pkg::mode_t MODE_UNDEF_FIRST = 4'd10;
  localparam sip_pkg::mode_t MODE_UNDEF_LAST  = 4'd15;

  localparam int IDLE_PCT     = 27;   // per-cycle chance of a gap or a stall
  localparam int RANDOM_REQS  = 200;
  localparam int TAIL_CYCLES  = 12;

  typedef struct {
    sip_pkg::mode_t mode;
    logic [63:0]    above;
    logic [31:0]    left;
    sip_pkg::pix_t  corner;
    bit             drain_first;  // hold this request until all rows are back
  } pred_req_t;

  typedef struct {
    sip_pkg::row_t pixels;
    logic [1:0]    index;
    logic          last;
  } row_res_t;

  typedef logic [3:0][3:0][7:0] block_t;  // [row][column][bit]

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;  // mode, above, left, corner, zero pad (lowest bits first)
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;       // row_pixels
  logic [1:0]   m_tuser;       // row_index
  logic         m_tlast;       // last_row

  pred_req_t req_queue[$];     // requests still to be offered
  row_res_t  rows_due[$];      // predicted rows, oldest first
  pred_req_t req_on_bus;       // request currently presented on s_tdata
  int        total_reqs = 0;
  int        reqs_taken = 0;
  int        rows_seen  = 0;
  int        err_count  = 0;

  subblock_intra_predictor_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset at start-up, then release it for good
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Give up well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("TIMEOUT: %0d of %0d requests taken, %0d rows outstanding",
             reqs_taken, total_reqs, rows_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction: rounding averages and the full 4x4 block for one request
  // ---------------------------------------------------------------------------
  function automatic int tap3(input int a, input int b, input int c);
    return (a + 2 * b + c + 2) >> 2;
  endfunction

  function automatic int tap2(input int a, input int b);
    return (a + b + 1) >> 1;
  endfunction

  function automatic block_t predict_block(input pred_req_t q);
    int     a[8];
    int     l[4];
    int     e[9];
    int     b[4][4];
    int     p, s, v, k, t, r, c, i;
    int     row_avg[4];
    block_t blk;
    for (i = 0; i < 8; i++) a[i] = q.above[8*i +: 8];
    for (i = 0; i < 4; i++) l[i] = q.left[8*i +: 8];
    p = q.corner;
    // Edge from the bottom-left pixel up through the corner to above pixel 3
    e[0] = l[3]; e[1] = l[2]; e[2] = l[1]; e[3] = l[0]; e[4] = p;
    e[5] = a[0]; e[6] = a[1]; e[7] = a[2]; e[8] = a[3];
    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) b[r][c] = 0;

    case (q.mode)
      sip_pkg::MODE_DC: begin
        // Rounded mean of the four above and four left pixels only
        s = 0;
        for (i = 0; i < 4; i++) s += a[i] + l[i];
        s = (s + 4) >> 3;
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) b[r][c] = s;
      end
      sip_pkg::MODE_TM: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) begin
            v = a[c] + l[r] - p;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            b[r][c] = v;
          end
      end
      sip_pkg::MODE_VE: begin
        row_avg[0] = tap3(p, a[0], a[1]);
        row_avg[1] = tap3(a[0], a[1], a[2]);
        row_avg[2] = tap3(a[1], a[2], a[3]);
        row_avg[3] = tap3(a[2], a[3], a[4]);
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) b[r][c] = row_avg[c];
      end
      sip_pkg::MODE_HE: begin
        // Bottom row repeats left pixel 3 beyond the edge
        row_avg[0] = tap3(p, l[0], l[1]);
        row_avg[1] = tap3(l[0], l[1], l[2]);
        row_avg[2] = tap3(l[1], l[2], l[3]);
        row_avg[3] = tap3(l[2], l[3], l[3]);
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) b[r][c] = row_avg[r];
      end
      sip_pkg::MODE_LD: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) begin
            k = r + c;
            if (k == 6) b[r][c] = tap3(a[6], a[7], a[7]);
            else b[r][c] = tap3(a[k], a[k+1], a[k+2]);
          end
      end
      sip_pkg::MODE_RD: begin
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) begin
            k = 3 - r + c;
            b[r][c] = tap3(e[k], e[k+1], e[k+2]);
          end
      end
      sip_pkg::MODE_VR: begin
        b[3][0] = tap3(e[1], e[2], e[3]);
        b[2][0] = tap3(e[2], e[3], e[4]);
        t = tap3(e[3], e[4], e[5]); b[3][1] = t; b[1][0] = t;
        t = tap2(e[4], e[5]);       b[2][1] = t; b[0][0] = t;
        t = tap3(e[4], e[5], e[6]); b[3][2] = t; b[1][1] = t;
        t = tap2(e[5], e[6]);       b[2][2] = t; b[0][1] = t;
        t = tap3(e[5], e[6], e[7]); b[3][3] = t; b[1][2] = t;
        t = tap2(e[6], e[7]);       b[2][3] = t; b[0][2] = t;
        b[1][3] = tap3(e[6], e[7], e[8]);
        b[0][3] = tap2(e[7], e[8]);
      end
      sip_pkg::MODE_VL: begin
        b[0][0] = tap2(a[0], a[1]);
        b[1][0] = tap3(a[0], a[1], a[2]);
        t = tap2(a[1], a[2]);       b[2][0] = t; b[0][1] = t;
        t = tap3(a[1], a[2], a[3]); b[1][1] = t; b[3][0] = t;
        t = tap2(a[2], a[3]);       b[2][1] = t; b[0][2] = t;
        t = tap3(a[2], a[3], a[4]); b[3][1] = t; b[1][2] = t;
        t = tap2(a[3], a[4]);       b[0][3] = t; b[2][2] = t;
        t = tap3(a[3], a[4], a[5]); b[1][3] = t; b[3][2] = t;
        b[2][3] = tap3(a[4], a[5], a[6]);
        b[3][3] = tap3(a[5], a[6], a[7]);
      end
      sip_pkg::MODE_HD: begin
        b[3][0] = tap2(e[0], e[1]);
        b[3][1] = tap3(e[0], e[1], e[2]);
        t = tap2(e[1], e[2]);       b[2][0] = t; b[3][2] = t;
        t = tap3(e[1], e[2], e[3]); b[2][1] = t; b[3][3] = t;
        t = tap2(e[2], e[3]);       b[2][2] = t; b[1][0] = t;
        t = tap3(e[2], e[3], e[4]); b[2][3] = t; b[1][1] = t;
        t = tap2(e[3], e[4]);       b[1][2] = t; b[0][0] = t;
        t = tap3(e[3], e[4], e[5]); b[1][3] = t; b[0][1] = t;
        b[0][2] = tap3(e[4], e[5], e[6]);
        b[0][3] = tap3(e[5], e[6], e[7]);
      end
      sip_pkg::MODE_HU: begin
        b[0][0] = tap2(l[0], l[1]);
        b[0][1] = tap3(l[0], l[1], l[2]);
        t = tap2(l[1], l[2]);       b[0][2] = t; b[1][0] = t;
        t = tap3(l[1], l[2], l[3]); b[0][3] = t; b[1][1] = t;
        t = tap2(l[2], l[3]);       b[1][2] = t; b[2][0] = t;
        t = tap3(l[2], l[3], l[3]); b[1][3] = t; b[2][1] = t;
        // Lower-right region copies left pixel 3 as it is
        b[2][2] = l[3]; b[2][3] = l[3];
        for (c = 0; c < 4; c++) b[3][c] = l[3];
      end
      default: ;  // undefined codes leave the block at zero
    endcase

    for (r = 0; r < 4; r++)
      for (c = 0; c < 4; c++) blk[r][c] = 8'(b[r][c]);
    return blk;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Bias towards the extremes so clamping and carries get exercised often
  function automatic sip_pkg::pix_t rand_pix();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_above();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_pix();
    return w;
  endfunction

  function automatic logic [31:0] rand_left();
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = rand_pix();
    return w;
  endfunction

  function automatic pred_req_t make_req(input sip_pkg::mode_t mode,
                                         input logic [63:0] above,
                                         input logic [31:0] left,
                                         input sip_pkg::pix_t corner,
                                         input bit drain_first);
    pred_req_t q;
    q.mode        = mode;
    q.above       = above;
    q.left        = left;
    q.corner      = corner;
    q.drain_first = drain_first;
    return q;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    // Keep the log readable if the block is badly broken
    if (err_count <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests on the slave stream, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    block_t   blk;
    row_res_t due_row;
    bit       taken;
    bit       idle_now;
    bit       quiet;
    int       r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        // The request on the bus went in at this edge: queue its four rows
        blk = predict_block(req_on_bus);
        for (r = 0; r < 4; r++) begin
          due_row.pixels = blk[r];
          due_row.index  = 2'(r);
          due_row.last   = (r == 3);
          rows_due.push_back(due_row);
        end
        reqs_taken++;
      end
      // A stretch in the middle of the run goes back to back with no random gaps
      quiet    = (reqs_taken >= 90) && (reqs_taken < 150);
      idle_now = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      // Only change the bus when nothing is held: valid stays put until taken
      if (!s_tvalid || taken) begin
        if (req_queue.size() != 0 && !idle_now &&
            !(req_queue[0].drain_first && rows_due.size() != 0)) begin
          req_on_bus = req_queue.pop_front();
          s_tdata  <= {4'b0000, req_on_bus.corner, req_on_bus.left,
                       req_on_bus.above, req_on_bus.mode};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take rows off the master stream and compare with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    row_res_t due_row;
    bit       quiet;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        rows_seen++;
        if (rows_due.size() == 0) begin
          report_mismatch($sformatf("row with no request pending: pixels %h row %0d last %0b",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
          due_row = rows_due.pop_front();
          if (m_tdata !== due_row.pixels)
            report_mismatch($sformatf("row %0d pixels %h, predicted %h",
                                      due_row.index, m_tdata, due_row.pixels));
          if (m_tuser !== due_row.index)
            report_mismatch($sformatf("row index %0d, predicted %0d",
                                      m_tuser, due_row.index));
          if (m_tlast !== due_row.last)
            report_mismatch($sformatf("row %0d last flag %0b, predicted %0b",
                                      due_row.index, m_tlast, due_row.last));
        end
      end
      // Stall at random, except for a stretch of rows taken without pause
      quiet = (rows_seen >= 360) && (rows_seen < 600);
      m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    sip_pkg::mode_t m;
    int             i;

    // Every defined mode once with random neighbours
    for (m = sip_pkg::MODE_DC; m <= sip_pkg::MODE_HU; m++)
      req_queue.push_back(make_req(m, rand_above(), rand_left(), rand_pix(), 1'b0));

    // TrueMotion at rest and at both ends of the clamp; drain before the first
    req_queue.push_back(make_req(sip_pkg::MODE_TM, '0, '0, 8'h00, 1'b0));
    req_queue.push_back(make_req(sip_pkg::MODE_TM, '1, '1, 8'h00, 1'b1));
    req_queue.push_back(make_req(sip_pkg::MODE_TM, '0, '0, 8'hFF, 1'b0));
    // DC mean at full scale
    req_queue.push_back(make_req(sip_pkg::MODE_DC, '1, '1, 8'hFF, 1'b0));
    // Diagonal down-left with a distinct last above-right pixel
    req_queue.push_back(make_req(sip_pkg::MODE_LD, 64'hFF40_2010_0804_0201, 32'h0, 8'h00,
                                 1'b0));
    // Horizontal and horizontal-up with a distinct bottom-left pixel
    req_queue.push_back(make_req(sip_pkg::MODE_HE, 64'h0, 32'hF010_8000, 8'h7F, 1'b0));
    req_queue.push_back(make_req(sip_pkg::MODE_HU, 64'h0, 32'h00FF_00FF, 8'h00, 1'b0));
    // Alternating bit patterns on every pixel field
    req_queue.push_back(make_req(sip_pkg::MODE_VE, {8{8'hAA}}, {4{8'h55}}, 8'hAA, 1'b0));
    req_queue.push_back(make_req(sip_pkg::MODE_RD, {8{8'h55}}, {4{8'hAA}}, 8'h55, 1'b0));
    // Undefined codes at both ends of their range
    req_queue.push_back(make_req(MODE_UNDEF_FIRST, rand_above(), rand_left(), rand_pix(),
                                 1'b0));
    req_queue.push_back(make_req(MODE_UNDEF_LAST, '1, '1, 8'hFF, 1'b0));
    // Remaining diagonals at the extremes
    req_queue.push_back(make_req(sip_pkg::MODE_VL, '1, '1, 8'hFF, 1'b0));
    req_queue.push_back(make_req(sip_pkg::MODE_HD, '0, '0, 8'h00, 1'b0));

    // Random requests: mostly defined modes, a few undefined codes, the odd drain
    for (i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 19) == 0)
        m = sip_pkg::mode_t'($urandom_range(MODE_UNDEF_FIRST, MODE_UNDEF_LAST));
      else
        m = sip_pkg::mode_t'($urandom_range(sip_pkg::MODE_DC, sip_pkg::MODE_HU));
      req_queue.push_back(make_req(m, rand_above(), rand_left(), rand_pix(),
                                   (i % 60) == 30));
    end
    total_reqs = req_queue.size();

    // Wait until every request is in and every predicted row has come back
    wait (rst == 1'b0);
    do @(posedge clk);
    while (reqs_taken != total_reqs || rows_due.size() != 0);
    // Let the pipeline run on in case a stray row follows
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (all ten modes, undefined codes, clamp and edge cases)",
             reqs_taken);
    $display("with %0d rows checked under random gaps, stalls and a drained pause", rows_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
